>>> rtl/fractal_simplex_noise_2d_defines.svh
// Assertion macros shared by the fractal simplex noise block.
`ifndef FRACTAL_SIMPLEX_NOISE_2D_DEFINES_SVH
`define FRACTAL_SIMPLEX_NOISE_2D_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define FSN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fsn assertion failed");

// Checks that a condition is followed by another in the next cycle.
`define FSN_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("fsn assertion failed");

`endif

>>> rtl/fsn_pkg.sv
// Shared types, widths and constants of the fractal simplex noise block.
package fsn_pkg;

  localparam int MAX_OCTAVES_DEF = 8;
  localparam int TABLE_SIZE      = 256;
  localparam int BYTE_W          = 8;
  localparam int COORD_W         = 32;
  localparam int SEL_W           = 3;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 17;
  localparam int COUNT_W         = 4;
  localparam int AMP_W           = 17;
  localparam int FRAC_W          = 24;
  localparam int OFS_W           = 26;
  localparam int TERM_W          = 24;
  localparam int GRAD_W          = 4;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LACUNARITY   = 1'b1;

  // Request opcodes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd1;
  localparam logic [AMP_W-1:0]   AMP_ONE     = 17'd65536;
  localparam logic [AMP_W-1:0]   AMP_HALF    = 17'd32768;

  // Skew and unskew factors.
  localparam logic [30:0] SKEW_Q32   = 31'd1572067139;
  localparam logic [29:0] UNSKEW_Q32 = 30'd907633386;
  localparam logic signed [OFS_W-1:0] ONE_Q24     = 26'sd16777216;
  localparam logic signed [OFS_W-1:0] UNSKEW_Q24  = 26'sd3545443;
  localparam logic signed [OFS_W-1:0] UNSKEW2_Q24 = 26'sd7090886;

  typedef struct packed {
    logic                              opcode;
    logic [SEL_W-1:0]                  octave_sel;
    logic [BYTE_W-1:0]                 perm_index;
    logic [BYTE_W-1:0]                 perm_value;
    logic signed [COORD_W-1:0]         x_coord;
    logic signed [COORD_W-1:0]         y_coord;
  } fsn_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] noise_value;
  } fsn_rsp_t;

endpackage

>>> rtl/fsn_stream_if.sv
// Valid/ready stream channel carrying one payload struct.
interface fsn_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/fsn_perm_ram.sv
// Permutation table memory with one write port and two registered read ports.
module fsn_perm_ram #(
  parameter int DEPTH = fsn_pkg::MAX_OCTAVES_DEF * fsn_pkg::TABLE_SIZE,
  parameter int AW    = 11
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [fsn_pkg::BYTE_W-1:0] wdata_i,
  input  logic [AW-1:0]             raddr_a_i,
  input  logic [AW-1:0]             raddr_b_i,
  output logic [fsn_pkg::BYTE_W-1:0] rdata_a_o,
  output logic [fsn_pkg::BYTE_W-1:0] rdata_b_o
);

  logic [fsn_pkg::BYTE_W-1:0] mem_q [DEPTH];
  logic [fsn_pkg::BYTE_W-1:0] rdata_a_q;
  logic [fsn_pkg::BYTE_W-1:0] rdata_b_q;

  // Write port and two synchronous read ports.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> rtl/fsn_corner.sv
// Five-stage pipeline for one simplex corner: falloff^4 times gradient dot.
module fsn_corner (
  input  logic                                clk_i,
  input  logic signed [fsn_pkg::OFS_W-1:0]    dx_i,
  input  logic signed [fsn_pkg::OFS_W-1:0]    dy_i,
  input  logic [fsn_pkg::GRAD_W-1:0]          grad_i,
  output logic signed [fsn_pkg::TERM_W-1:0]   term_o
);

  localparam int OFS_W  = fsn_pkg::OFS_W;
  localparam int FRAC_W = fsn_pkg::FRAC_W;
  localparam int SQ_W   = 2 * OFS_W;
  localparam int RF_W   = SQ_W - FRAC_W + 2;
  localparam int R_W    = 24;
  localparam int R2_W   = 23;
  localparam int R4_W   = 21;
  localparam int DOT_W  = OFS_W + 1;
  localparam int P_W    = R4_W + 1 + DOT_W;
  localparam logic signed [RF_W-1:0] HALF_Q24 = RF_W'(8388608);

  // Gradient dot product for one of the twelve gradient directions.
  function automatic logic signed [DOT_W-1:0] grad_dot(
    input logic [fsn_pkg::GRAD_W-1:0] g,
    input logic signed [OFS_W-1:0]    dx,
    input logic signed [OFS_W-1:0]    dy
  );
    logic signed [DOT_W-1:0] ex;
    logic signed [DOT_W-1:0] ey;
    logic signed [DOT_W-1:0] xt;
    logic signed [DOT_W-1:0] yt;
    ex = DOT_W'(dx);
    ey = DOT_W'(dy);
    if (g < 4'd8) begin
      xt = g[0] ? -ex : ex;
    end else begin
      xt = '0;
    end
    if (g < 4'd4) begin
      yt = g[1] ? -ey : ey;
    end else if (g < 4'd8) begin
      yt = '0;
    end else begin
      yt = g[0] ? -ey : ey;
    end
    return xt + yt;
  endfunction

  logic signed [SQ_W-1:0]  sq_x_d, sq_y_d;
  logic signed [SQ_W-1:0]  sq_x_q, sq_y_q;
  logic signed [OFS_W-1:0] dx_q, dy_q;
  logic signed [RF_W-1:0]  r_full;
  logic [R_W-1:0]          r_d, r_q;
  logic signed [DOT_W-1:0] dot_d, dot_q, dot2_q, dot3_q;
  logic [2*R_W-1:0]        r_sq;
  logic [R2_W-1:0]         r2_q;
  logic [2*R2_W-1:0]       r2_sq;
  logic [R4_W-1:0]         r4_q;
  logic signed [P_W-1:0]   prod;
  logic signed [P_W-FRAC_W-1:0] quo;
  logic signed [fsn_pkg::TERM_W-1:0] term_d, term_q;

  // Stage a: squared offsets.
  assign sq_x_d = dx_i * dx_i;
  assign sq_y_d = dy_i * dy_i;

  // Stage b: falloff radius clipped at zero, and gradient dot product.
  assign r_full = HALF_Q24 - $signed({2'b00, sq_x_q[SQ_W-1:FRAC_W]})
                           - $signed({2'b00, sq_y_q[SQ_W-1:FRAC_W]});
  assign r_d    = (r_full > 0) ? r_full[R_W-1:0] : '0;
  assign dot_d  = grad_dot(grad_i, dx_q, dy_q);

  // Stages c and d: squaring the falloff twice.
  assign r_sq  = r_q * r_q;
  assign r2_sq = r2_q * r2_q;

  // Stage e: scale by the dot product, rounding toward zero.
  assign prod   = $signed({1'b0, r4_q}) * dot3_q;
  assign quo    = prod[P_W-1:FRAC_W];
  assign term_d = (prod < 0 && prod[FRAC_W-1:0] != '0) ?
                  fsn_pkg::TERM_W'(quo + 1'b1) : fsn_pkg::TERM_W'(quo);

  always_ff @(posedge clk_i) begin
    sq_x_q <= sq_x_d;
    sq_y_q <= sq_y_d;
    dx_q   <= dx_i;
    dy_q   <= dy_i;
    r_q    <= r_d;
    dot_q  <= dot_d;
    r2_q   <= r_sq[FRAC_W+R2_W-1:FRAC_W];
    dot2_q <= dot_q;
    r4_q   <= r2_sq[FRAC_W+R4_W-1:FRAC_W];
    dot3_q <= dot2_q;
    term_q <= term_d;
  end

  assign term_o = term_q;

endmodule

>>> rtl/fractal_simplex_noise_2d.sv
// Top level of the fractal two-dimensional simplex noise block.
// An evaluate request takes the programmed octave count N (saturated to MAX_OCTAVES)
// and runs one octave per cycle through a twelve-stage pipeline: skew, corner selection,
// two dependent permutation lookups, the corner falloff math and the amplitude weighting.
// The result is valid once all N octaves have passed the twelve pipeline stages into the
// accumulator and the output register has been loaded. A stalled output holds the block
// in its done state; the next request is taken only once it is idle again. A count of
// zero goes straight to the done state and returns 0. A permutation write is done on
// acceptance and keeps the block idle. One request is in flight at a time, but the next
// request is taken while a finished result still waits in the output register. The
// permutation tables are held in three copies so that each corner has its own pair of
// read ports; entries read before being written return undefined data.
`include "fractal_simplex_noise_2d_defines.svh"
module fractal_simplex_noise_2d #(
  parameter int MAX_OCTAVES = fsn_pkg::MAX_OCTAVES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  fsn_stream_if.sink                          in_i,
  fsn_stream_if.source                        out_o,
  input  logic                                cfg_we_i,
  input  logic [fsn_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [fsn_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int OCT_W     = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int CNT_W     = $clog2(MAX_OCTAVES + 1);
  localparam int RAM_DEPTH = MAX_OCTAVES * fsn_pkg::TABLE_SIZE;
  localparam int RAM_AW    = OCT_W + fsn_pkg::BYTE_W;
  localparam int BYTE_W    = fsn_pkg::BYTE_W;
  localparam int AMP_W     = fsn_pkg::AMP_W;
  localparam int FRAC_W    = fsn_pkg::FRAC_W;
  localparam int OFS_W     = fsn_pkg::OFS_W;
  localparam int TERM_W    = fsn_pkg::TERM_W;
  localparam int NSTAGE    = 12;
  localparam int S_W       = 56;
  localparam int MUL_W     = 59;
  localparam int HALF_W    = 28;
  localparam int T_W       = 23;
  localparam int TP_W      = 55;
  localparam int SUM_W     = TERM_W + 2;
  localparam int V_W       = 33;
  localparam int WP_W      = V_W + AMP_W + 1;
  localparam int W_W       = WP_W - 16;
  localparam int ACC_W     = 40;
  localparam int NCORNER   = 3;
  localparam logic signed [V_W-1:0] NOISE_GAIN = V_W'(70);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(64'sd2147483648);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  typedef struct packed {
    logic             last;
    logic [CNT_W-1:0] n;
    logic [AMP_W-1:0] amp;
  } meta_t;

  // Remainder modulo twelve by reciprocal multiplication.
  function automatic logic [fsn_pkg::GRAD_W-1:0] mod12(input logic [BYTE_W-1:0] v);
    logic [16:0]       prod;
    logic [5:0]        quo;
    logic [BYTE_W-1:0] rem_full;
    prod     = 17'(v) * 17'd171;
    quo      = prod[16:11];
    rem_full = v - (8'(quo) * 8'd12);
    return rem_full[fsn_pkg::GRAD_W-1:0];
  endfunction

  fsn_pkg::fsn_req_t req;
  logic in_fire, out_free, xfer;
  logic wr_en, sel_ok;
  logic [OCT_W+fsn_pkg::SEL_W-1:0] sel_ext;
  logic [RAM_AW-1:0] wr_addr;

  logic [fsn_pkg::COUNT_W-1:0] count_q;
  logic [AMP_W-1:0]            lac_q, lac_eff;
  logic [CNT_W-1:0]            cnt_d;

  logic [1:0]         state_q;
  logic [CNT_W-1:0]   oct_q, cnt_q;
  logic [AMP_W-1:0]   amp_q, lac_use_q;
  logic [2*AMP_W-1:0] amp_prod;
  logic               issue_last;
  logic signed [fsn_pkg::COORD_W-1:0] x_q, y_q;

  logic               valid_q [NSTAGE];
  meta_t              meta_q  [NSTAGE];

  logic [63:0]        sx64, sy64;
  logic [S_W-1:0]     s_d, s_q;
  logic [FRAC_W-1:0]  sxl_q, syl_q, sxl2_q, syl2_q;
  logic [MUL_W-1:0]   pl_d, ph_d;
  logic [S_W-1:0]     pl_q;
  logic [HALF_W-1:0]  ph_q;
  logic [S_W-1:0]     skew, xs, ys;
  logic [BYTE_W-1:0]  ci_q, cj_q, ci4_q, cj4_q, ci5_q;
  logic [FRAC_W-1:0]  fx_q, fy_q, fx4_q, fy4_q;
  logic [FRAC_W:0]    fsum;
  logic [TP_W-1:0]    tprod;
  logic [T_W-1:0]     t_q;
  logic signed [OFS_W-1:0] x0, y0;
  logic               mi, mi5_q;
  logic signed [OFS_W-1:0] dx_d [NCORNER];
  logic signed [OFS_W-1:0] dy_d [NCORNER];
  logic signed [OFS_W-1:0] dx_q [NCORNER];
  logic signed [OFS_W-1:0] dy_q [NCORNER];
  logic [BYTE_W-1:0]  l1_off [NCORNER];
  logic [BYTE_W-1:0]  l2_off [NCORNER];
  logic [RAM_AW-1:0]  l1_addr [NCORNER];
  logic [RAM_AW-1:0]  l2_addr [NCORNER];
  logic [BYTE_W-1:0]  p1 [NCORNER];
  logic [BYTE_W-1:0]  p2 [NCORNER];
  logic signed [TERM_W-1:0] term [NCORNER];

  logic signed [SUM_W-1:0] sum3;
  logic signed [V_W-1:0]   v_d, v_q;
  logic signed [WP_W-1:0]  wprod;
  logic signed [W_W-1:0]   w_d, w_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                    out_valid_q;
  logic signed [fsn_pkg::COORD_W-1:0] noise_q, noise_d;

  // Request handshake and permutation write decode.
  assign req       = in_i.data;
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire   = in_i.valid && in_i.ready;
  assign sel_ok    = (int'(req.octave_sel) < MAX_OCTAVES);
  assign sel_ext   = (OCT_W + fsn_pkg::SEL_W)'(req.octave_sel);
  assign wr_en     = in_fire && (req.opcode == fsn_pkg::OP_WRITE) && sel_ok;
  assign wr_addr   = {sel_ext[OCT_W-1:0], req.perm_index};

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= fsn_pkg::COUNT_RESET;
      lac_q   <= fsn_pkg::AMP_HALF;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fsn_pkg::REG_OCTAVE_COUNT: count_q <= cfg_data_i[fsn_pkg::COUNT_W-1:0];
        fsn_pkg::REG_LACUNARITY:   lac_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective octave count and amplitude factor.
  assign cnt_d   = (int'(count_q) > MAX_OCTAVES) ? CNT_W'(MAX_OCTAVES) : CNT_W'(count_q);
  assign lac_eff = (lac_q > fsn_pkg::AMP_ONE) ? fsn_pkg::AMP_HALF : lac_q;

  // Octave issue: amplitude update and last-octave flag.
  assign amp_prod   = amp_q * lac_use_q;
  assign issue_last = (CNT_W'(oct_q + 1'b1) == cnt_q);
  assign out_free   = !out_valid_q || out_o.ready;
  assign xfer       = (state_q == ST_DONE) && out_free;

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      oct_q   <= '0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_fire && req.opcode == fsn_pkg::OP_EVAL) begin
            oct_q   <= '0;
            cnt_q   <= cnt_d;
            state_q <= (cnt_d == '0) ? ST_DONE : ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          oct_q <= CNT_W'(oct_q + 1'b1);
          if (issue_last) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (valid_q[NSTAGE-1] && meta_q[NSTAGE-1].last) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Sample point, amplitude and accumulator.
  always_ff @(posedge clk_i) begin
    if (in_fire && req.opcode == fsn_pkg::OP_EVAL) begin
      x_q       <= req.x_coord;
      y_q       <= req.y_coord;
      lac_use_q <= lac_eff;
      amp_q     <= fsn_pkg::AMP_ONE;
      acc_q     <= '0;
    end else begin
      if (state_q == ST_ISSUE) begin
        amp_q <= amp_prod[AMP_W+15:16];
      end
      if (valid_q[NSTAGE-1]) begin
        acc_q <= acc_q + ACC_W'(w_q);
      end
    end
  end

  // Valid bits travel alongside the stage registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NSTAGE; k++) begin
        valid_q[k] <= 1'b0;
      end
    end else begin
      valid_q[0] <= (state_q == ST_ISSUE);
      for (int k = 1; k < NSTAGE; k++) begin
        valid_q[k] <= valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    meta_q[0] <= '{last: issue_last, n: oct_q, amp: amp_q};
    for (int k = 1; k < NSTAGE; k++) begin
      meta_q[k] <= meta_q[k-1];
    end
  end

  // Stage 1: octave scaling and coordinate sum.
  assign sx64 = 64'(x_q) << oct_q;
  assign sy64 = 64'(y_q) << oct_q;
  assign s_d  = sx64[S_W-1:0] + sy64[S_W-1:0];

  // Stage 2: skew product in two halves.
  assign pl_d = s_q[HALF_W-1:0] * fsn_pkg::SKEW_Q32;
  assign ph_d = s_q[S_W-1:HALF_W] * fsn_pkg::SKEW_Q32;

  // Stage 3: skewed coordinates, cell index and fraction.
  assign skew = pl_q + {ph_q, {HALF_W{1'b0}}};
  assign xs   = skew + {sxl2_q, 32'd0};
  assign ys   = skew + {syl2_q, 32'd0};

  // Stage 4: unskew offset.
  assign fsum  = {1'b0, fx_q} + {1'b0, fy_q};
  assign tprod = fsum * fsn_pkg::UNSKEW_Q32;

  // Stage 5: corner offsets and triangle choice.
  assign x0 = $signed({2'b00, fx4_q}) - $signed({3'b000, t_q});
  assign y0 = $signed({2'b00, fy4_q}) - $signed({3'b000, t_q});
  assign mi = (x0 > y0);

  assign dx_d[0] = x0;
  assign dy_d[0] = y0;
  assign dx_d[1] = x0 - (mi ? fsn_pkg::ONE_Q24 : '0) + fsn_pkg::UNSKEW_Q24;
  assign dy_d[1] = y0 - (mi ? '0 : fsn_pkg::ONE_Q24) + fsn_pkg::UNSKEW_Q24;
  assign dx_d[2] = x0 - fsn_pkg::ONE_Q24 + fsn_pkg::UNSKEW2_Q24;
  assign dy_d[2] = y0 - fsn_pkg::ONE_Q24 + fsn_pkg::UNSKEW2_Q24;

  assign l1_off[0] = '0;
  assign l1_off[1] = BYTE_W'(!mi);
  assign l1_off[2] = 8'd1;
  assign l2_off[0] = '0;
  assign l2_off[1] = BYTE_W'(mi5_q);
  assign l2_off[2] = 8'd1;

  always_ff @(posedge clk_i) begin
    s_d_reg: begin
      s_q    <= s_d;
      sxl_q  <= sx64[FRAC_W-1:0];
      syl_q  <= sy64[FRAC_W-1:0];
    end
    pl_q   <= pl_d[S_W-1:0];
    ph_q   <= ph_d[HALF_W-1:0];
    sxl2_q <= sxl_q;
    syl2_q <= syl_q;
    ci_q   <= xs[S_W-1:48];
    cj_q   <= ys[S_W-1:48];
    fx_q   <= xs[47:FRAC_W];
    fy_q   <= ys[47:FRAC_W];
    t_q    <= tprod[TP_W-1:32];
    ci4_q  <= ci_q;
    cj4_q  <= cj_q;
    fx4_q  <= fx_q;
    fy4_q  <= fy_q;
    ci5_q  <= ci4_q;
    mi5_q  <= mi;
    for (int k = 0; k < NCORNER; k++) begin
      dx_q[k] <= dx_d[k];
      dy_q[k] <= dy_d[k];
    end
  end

  // Per-corner table copies: first lookup in stage 5, second in stage 6.
  for (genvar c = 0; c < NCORNER; c++) begin : g_corner
    assign l1_addr[c] = {meta_q[3].n[OCT_W-1:0], BYTE_W'(cj4_q + l1_off[c])};
    assign l2_addr[c] = {meta_q[4].n[OCT_W-1:0], BYTE_W'(ci5_q + l2_off[c] + p1[c])};

    fsn_perm_ram #(
      .DEPTH (RAM_DEPTH),
      .AW    (RAM_AW)
    ) u_ram (
      .clk_i     (clk_i),
      .we_i      (wr_en),
      .waddr_i   (wr_addr),
      .wdata_i   (req.perm_value),
      .raddr_a_i (l1_addr[c]),
      .raddr_b_i (l2_addr[c]),
      .rdata_a_o (p1[c]),
      .rdata_b_o (p2[c])
    );

    fsn_corner u_corner (
      .clk_i  (clk_i),
      .dx_i   (dx_q[c]),
      .dy_i   (dy_q[c]),
      .grad_i (mod12(p2[c])),
      .term_o (term[c])
    );
  end

  // Stage 11: corner sum times the noise gain.
  assign sum3 = SUM_W'(term[0]) + SUM_W'(term[1]) + SUM_W'(term[2]);
  assign v_d  = V_W'(sum3) * NOISE_GAIN;

  // Stage 12: amplitude weighting, rounding toward zero.
  assign wprod = v_q * $signed({1'b0, meta_q[10].amp});
  assign w_d   = (wprod < 0 && wprod[15:0] != '0) ?
                 W_W'(wprod[WP_W-1:16] + 1'b1) : wprod[WP_W-1:16];

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    w_q <= w_d;
  end

  // Output register with saturation to Q8.24.
  assign noise_d = (acc_q > SAT_MAX) ? SAT_MAX[fsn_pkg::COORD_W-1:0] :
                   (acc_q < SAT_MIN) ? SAT_MIN[fsn_pkg::COORD_W-1:0] :
                   acc_q[fsn_pkg::COORD_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer) begin
      noise_q <= noise_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.data.noise_value = noise_q;

  // Assertions.
  `FSN_ASSERT(a_tail_in_flight, valid_q[NSTAGE-1] |-> (state_q == ST_ISSUE || state_q == ST_DRAIN))
  `FSN_ASSERT(a_oct_bound, (state_q == ST_ISSUE) |-> (oct_q < cnt_q))
  `FSN_ASSERT_NEXT(a_done_delivers, xfer, out_o.valid && state_q == ST_IDLE)

endmodule

>>> test/fractal_simplex_noise_2d_tb.sv
// Self-checking testbench of the fractal two-dimensional simplex noise block.
`timescale 1ns / 1ps
module fractal_simplex_noise_2d_tb;

  localparam int  LIMIT_CYCLES = 2000000;
  localparam int  SETTLE       = 40;
  localparam int  LONG_HOLD    = 300;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [fsn_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [fsn_pkg::CFG_DATA_W-1:0] cfg_data_i;

  fsn_stream_if #(.payload_t(fsn_pkg::fsn_req_t)) in_if ();
  fsn_stream_if #(.payload_t(fsn_pkg::fsn_rsp_t)) out_if ();

  int  mismatches;
  int  cycles;
  bit  idle_en;
  bit  hold_req;
  bit  hold_done;
  int  hold_left;

  fractal_simplex_noise_2d i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Prints one mismatch line and counts it.
  task automatic report(input string msg);
    $display("ERROR @%0d: %s", cycles, msg);
    mismatches++;
  endtask

  // Noise predictor with its own copy of the tables and registers.
  class noise_scoreboard;
    bit [7:0]        tab[8][256];
    bit [3:0]        oct_count;
    bit [16:0]       lac_reg;
    logic signed [31:0] expected_q[$];

    function new();
      oct_count = fsn_pkg::COUNT_RESET;
      lac_reg   = fsn_pkg::AMP_HALF;
    endfunction

    function automatic longint corner(longint dx, longint dy, int g);
      longint one, r, r2, r4, gx, gy;
      one = 64'sd16777216;
      r = 64'sd8388608 - (dx * dx) / one - (dy * dy) / one;
      if (r <= 0) return 0;
      r2 = (r * r) / one;
      r4 = (r2 * r2) / one;
      gx = (g < 8) ? ((g % 2) ? -1 : 1) : 0;
      gy = (g < 2) ? 1 : (g < 4) ? -1 : (g < 8) ? 0 : ((g % 2) ? -1 : 1);
      return (r4 * (gx * dx + gy * dy)) / one;
    endfunction

    function automatic longint octave(int n, bit [63:0] xu, bit [63:0] yu);
      bit [63:0] sx, sy, skew, xs, ys, fx, fy, t;
      int ci, cj, mi, mj, g0, g1, g2;
      longint x0, y0, one, s;
      one  = 64'sd16777216;
      sx   = xu << n;
      sy   = yu << n;
      skew = (sx + sy) * 64'd1572067139;
      xs   = (sx << 32) + skew;
      ys   = (sy << 32) + skew;
      ci   = int'(xs[55:48]);
      cj   = int'(ys[55:48]);
      fx   = {40'd0, xs[47:24]};
      fy   = {40'd0, ys[47:24]};
      t    = ((fx + fy) * 64'd907633386) >> 32;
      x0   = longint'(fx) - longint'(t);
      y0   = longint'(fy) - longint'(t);
      mi   = (x0 > y0) ? 1 : 0;
      mj   = 1 - mi;
      g0 = tab[n][(ci + tab[n][cj]) & 255] % 12;
      g1 = tab[n][(ci + mi + tab[n][(cj + mj) & 255]) & 255] % 12;
      g2 = tab[n][(ci + 1 + tab[n][(cj + 1) & 255]) & 255] % 12;
      s  = corner(x0, y0, g0);
      s += corner(x0 - mi * one + 3545443, y0 - mj * one + 3545443, g1);
      s += corner(x0 - one + 7090886, y0 - one + 7090886, g2);
      return s * 70;
    endfunction

    function void set_reg(logic [fsn_pkg::CFG_IDX_W-1:0] idx,
                          logic [fsn_pkg::CFG_DATA_W-1:0] val);
      if (idx == fsn_pkg::REG_OCTAVE_COUNT) oct_count = val[3:0];
      else lac_reg = val;
    endfunction

    // Notes an accepted request and queues the noise it should produce.
    function void note_request(fsn_pkg::fsn_req_t r);
      bit [63:0] xu, yu, amp, lac;
      longint total;
      int cnt;
      if (r.opcode == fsn_pkg::OP_WRITE) begin
        tab[r.octave_sel][r.perm_index] = r.perm_value;
        return;
      end
      xu  = {{32{r.x_coord[31]}}, r.x_coord};
      yu  = {{32{r.y_coord[31]}}, r.y_coord};
      cnt = (oct_count > 8) ? 8 : int'(oct_count);
      lac = (lac_reg > 17'd65536) ? 64'd32768 : 64'(lac_reg);
      amp = 64'd65536;
      total = 0;
      for (int n = 0; n < cnt; n++) begin
        total += (octave(n, xu, yu) * longint'(amp)) / 65536;
        amp = (amp * lac) >> 16;
      end
      if (total > 64'sd2147483647) total = 64'sd2147483647;
      if (total < -64'sd2147483648) total = -64'sd2147483648;
      expected_q.push_back(total[31:0]);
    endfunction

    // Compares one returned noise value with the oldest expectation.
    task check_result(fsn_pkg::fsn_rsp_t rsp);
      logic signed [31:0] exp_v;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result noise_value=%0d", rsp.noise_value));
        return;
      end
      exp_v = expected_q.pop_front();
      if (rsp.noise_value !== exp_v)
        report($sformatf("noise_value got %0d expected %0d", rsp.noise_value, exp_v));
    endtask
  endclass

  noise_scoreboard sb;

  // Clock.
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Watches both channels at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.note_request(in_if.data);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
    end
  end

  // Cycle limit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result ready with random stalls and one long hold-off.
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !(idle_en && ($urandom_range(99) < 13));
    end
  end

  // Offers one request and returns after it is accepted.
  task automatic send_req(input fsn_pkg::fsn_req_t r);
    if (idle_en && ($urandom_range(99) < 13)) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.data  = r;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic send_write(input int sel, input int idx, input int val);
    fsn_pkg::fsn_req_t r;
    r = '0;
    r.opcode     = fsn_pkg::OP_WRITE;
    r.octave_sel = sel[2:0];
    r.perm_index = idx[7:0];
    r.perm_value = val[7:0];
    r.x_coord    = $urandom;
    r.y_coord    = $urandom;
    send_req(r);
  endtask

  task automatic send_eval(input logic [31:0] x, input logic [31:0] y);
    fsn_pkg::fsn_req_t r;
    r = '0;
    r.opcode     = fsn_pkg::OP_EVAL;
    r.octave_sel = 3'($urandom);
    r.perm_index = 8'($urandom);
    r.perm_value = 8'($urandom);
    r.x_coord    = x;
    r.y_coord    = y;
    send_req(r);
  endtask

  // Waits until every expected result has come and the block has settled.
  task automatic drain();
    in_if.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [fsn_pkg::CFG_IDX_W-1:0] idx, input int val);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val[fsn_pkg::CFG_DATA_W-1:0];
    sb.set_reg(idx, cfg_data_i);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom_range(32'h0008_0000) - 32'h0004_0000;
      2:       return $urandom_range(32'h0100_0000) - 32'h0080_0000;
      default: return $urandom_range(32'h0000_FFFF);
    endcase
  endfunction

  // Random mix of table rewrites and evaluations.
  task automatic random_phase(input int n_items);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < 20)
        send_write($urandom_range(7), $urandom_range(255), $urandom_range(255));
      else
        send_eval(rand_coord(), rand_coord());
    end
  endtask

  initial begin
    int cnts[8];
    int lacs[8];
    sb = new();
    idle_en     = 1'b1;
    hold_req    = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = fsn_pkg::REG_OCTAVE_COUNT;
    cfg_data_i  = '0;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Fill every table so that no evaluation reads an unwritten entry.
    for (int o = 0; o < 8; o++)
      for (int k = 0; k < 256; k++)
        send_write(o, k, $urandom_range(255));

    // Directed points under the reset settings, then at full depth.
    send_eval(32'h0000_0000, 32'h0000_0000);
    send_eval(32'h7FFF_FFFF, 32'h8000_0000);
    send_eval(32'h8000_0000, 32'h8000_0000);
    send_eval(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_eval(32'h0000_8000, 32'hFFFF_8000);
    send_write(3, 8'h00, 8'hFF);
    send_write(7, 8'hFF, 8'h00);
    send_eval(32'hFFFF_FFFF, 32'h0000_0001);
    drain();
    write_reg(fsn_pkg::REG_OCTAVE_COUNT, 8);
    write_reg(fsn_pkg::REG_LACUNARITY, 65536);
    send_eval(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_eval(32'h8000_0000, 32'h7FFF_FFFF);
    send_eval(32'h0001_2345, 32'hFFFE_DCBA);
    send_eval(32'h0000_0000, 32'h0000_0000);
    drain();
    // Zero octaves return zero; a count above the table count saturates.
    write_reg(fsn_pkg::REG_OCTAVE_COUNT, 0);
    send_eval(32'h1234_5678, 32'h8765_4321);
    drain();
    write_reg(fsn_pkg::REG_OCTAVE_COUNT, 15);
    write_reg(fsn_pkg::REG_LACUNARITY, 131071);
    send_eval(32'h0003_8000, 32'h0001_4000);
    send_eval(32'hC000_0000, 32'h4000_0000);
    drain();

    // Random phases through several register settings.
    cnts = '{8, 1, 0, 15, 3, 8, 5, 8};
    lacs = '{65536, 0, 32768, 65537, 0, 131071, 0, 32768};
    lacs[4] = $urandom_range(65536);
    lacs[6] = $urandom_range(65536);
    for (int p = 0; p < 8; p++) begin
      write_reg(fsn_pkg::REG_OCTAVE_COUNT, cnts[p]);
      write_reg(fsn_pkg::REG_LACUNARITY, lacs[p]);
      idle_en = (p != 2);
      if (p == 3) hold_req = 1'b1;
      random_phase(90);
      // The sender pauses until all results are back, then resumes.
      if (p == 5) begin
        in_if.valid = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge clk_i);
      end
      random_phase(90);
      drain();
    end
    idle_en = 1'b1;

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/fsn_pkg.sv
rtl/fsn_stream_if.sv
rtl/fsn_perm_ram.sv
rtl/fsn_corner.sv
rtl/fractal_simplex_noise_2d.sv
test/fractal_simplex_noise_2d_tb.sv
